FILE: rtl/core/edf_pkg.sv
// Shared types and constants of the EDF task dispatcher.
// No dependencies; imported by every module of the block.
package edf_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = 5;
    localparam int HOR_W     = 16;
    localparam int FIELD_W   = 16;
    localparam int TIME_W    = 17;
    localparam int DL_W      = 18;
    localparam int EN_W      = 24;

    localparam logic [EN_W-1:0] BUSY_ENERGY = EN_W'(100);
    localparam logic [EN_W-1:0] IDLE_ENERGY = EN_W'(40);

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic REG_TASK_COUNT = 1'b0;
    localparam logic REG_HORIZON    = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_ENERGY,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // write one task entry from the input word
        logic start;     // latch slot start, clear best candidate
        logic scan;      // examine the entry under the scan index
        logic commit;    // advance time and the chosen entry
        logic energy;    // add the slot's energy
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic at_horizon;
        logic count_zero;
        logic scan_last;
    } t_status;

endpackage

FILE: rtl/core/edf_ctrl.sv
// Sequencer of the EDF task dispatcher: accepts words, steps the scan,
// commit and energy phases, and owns the output valid flag. Uses edf_pkg.
module edf_ctrl import edf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic    o_out_load,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_out_load  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        priority if (i_status.at_horizon) n_state = S_DONE;
                        else if (i_status.count_zero)     n_state = S_COMMIT;
                        else                              n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_ENERGY;
            end
            S_ENERGY: begin
                o_cmd.energy = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTH
    a_scan_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> !(o_cmd.load || o_cmd.start) || (r_state == S_IDLE))
        else $error("new word taken during scan");
    a_load_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_load && r_out_valid) |-> i_out_ready)
        else $error("pending result overwritten");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_load |=> r_out_valid && (r_state == S_IDLE))
        else $error("result not presented after load");
`endif

endmodule

FILE: rtl/core/edf_datapath.sv
// Datapath of the EDF task dispatcher: task table, ready marks, scan
// compare, time and energy registers, result register. Uses edf_pkg.
module edf_datapath import edf_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [CNT_W-1:0]    i_task_count,
    input  logic [HOR_W-1:0]    i_horizon,
    input  logic [IDX_W-1:0]    i_task_index,
    input  logic [FIELD_W-1:0]  i_first_arrival,
    input  logic [FIELD_W-1:0]  i_run_length,
    input  logic [FIELD_W-1:0]  i_first_deadline,
    input  logic [FIELD_W-1:0]  i_task_period,
    input  logic                i_out_load,
    output logic [TIME_W-1:0]   o_slot_start,
    output logic [TIME_W-1:0]   o_slot_end,
    output logic [IDX_W-1:0]    o_served_task,
    output logic                o_slot_idle,
    output logic                o_horizon_reached,
    output logic [EN_W-1:0]     o_energy_total
);

    // task table
    logic [TIME_W-1:0]  r_rel   [MAX_TASKS];
    logic [DL_W-1:0]    r_dl    [MAX_TASKS];
    logic [FIELD_W-1:0] r_len   [MAX_TASKS];
    logic [FIELD_W-1:0] r_per   [MAX_TASKS];
    logic [TIME_W-1:0]  r_stamp [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_mark;

    logic [TIME_W-1:0]  r_time, r_start;
    logic [EN_W-1:0]    r_energy;
    logic [IDX_W-1:0]   r_idx;
    logic               r_hz, r_idle;

    // best candidate so far
    logic               r_best_valid;
    logic [IDX_W-1:0]   r_best_idx;
    logic [DL_W-1:0]    r_best_dl;
    logic [TIME_W-1:0]  r_best_stamp;
    logic [TIME_W-1:0]  r_best_rel;
    logic [FIELD_W-1:0] r_best_len;
    logic [FIELD_W-1:0] r_best_per;

    logic [TIME_W-1:0]  r_o_start, r_o_end;
    logic [IDX_W-1:0]   r_o_task;
    logic               r_o_idle, r_o_hz;
    logic [EN_W-1:0]    r_o_energy;

    logic [CNT_W-1:0]   count_eff;
    logic [TIME_W-1:0]  c_rel, c_stamp;
    logic [DL_W-1:0]    c_dl;
    logic               c_ready, c_better;
    logic [TIME_W:0]    time_sum;
    logic [TIME_W-1:0]  n_time;
    logic [TIME_W:0]    rel_sum;
    logic [DL_W:0]      dl_sum;
    logic [TIME_W-1:0]  delta;
    logic [EN_W-1:0]    amount;
    logic [EN_W:0]      en_sum;

    assign count_eff = (i_task_count > CNT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : i_task_count;

    assign o_status.at_horizon = (r_time >= {1'b0, i_horizon});
    assign o_status.count_zero = (count_eff == '0);
    assign o_status.scan_last  = ({1'b0, r_idx} == (count_eff - CNT_W'(1)));

    // entry under the scan index
    assign c_rel    = r_rel[r_idx];
    assign c_dl     = r_dl[r_idx];
    assign c_ready  = r_mark[r_idx] || (c_rel <= r_time);
    assign c_stamp  = r_mark[r_idx] ? r_stamp[r_idx] : c_rel;
    assign c_better = !r_best_valid || (c_dl < r_best_dl) ||
                      ((c_dl == r_best_dl) && (c_stamp < r_best_stamp));

    // saturating time advance: run length when a task runs, else one tick
    assign time_sum = {1'b0, r_time} +
                      (r_best_valid ? (TIME_W+1)'(r_best_len) : (TIME_W+1)'(1));
    assign n_time   = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
    assign rel_sum  = {1'b0, r_best_rel} + (TIME_W+1)'(r_best_per);
    assign dl_sum   = {1'b0, r_best_dl} + (DL_W+1)'(r_best_per);

    assign delta  = r_time - r_start;
    assign amount = r_idle ? IDLE_ENERGY : (EN_W'(delta) * BUSY_ENERGY);
    assign en_sum = {1'b0, r_energy} + {1'b0, amount};

    // table contents need no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rel[i_task_index] <= TIME_W'(i_first_arrival);
            r_dl[i_task_index]  <= DL_W'(i_first_deadline);
            r_len[i_task_index] <= i_run_length;
            r_per[i_task_index] <= i_task_period;
        end else if (i_cmd.commit && r_best_valid) begin
            r_rel[r_best_idx] <= rel_sum[TIME_W] ? '1 : rel_sum[TIME_W-1:0];
            r_dl[r_best_idx]  <= dl_sum[DL_W] ? '1 : dl_sum[DL_W-1:0];
        end
        if (i_cmd.scan && c_ready && !r_mark[r_idx]) begin
            r_stamp[r_idx] <= c_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark   <= '0;
            r_time   <= '0;
            r_energy <= '0;
        end else begin
            if (i_cmd.load) begin
                r_mark[i_task_index] <= 1'b0;
            end else if (i_cmd.scan && c_ready) begin
                r_mark[r_idx] <= 1'b1;
            end else if (i_cmd.commit && r_best_valid) begin
                r_mark[r_best_idx] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_time <= n_time;
            end
            if (i_cmd.energy) begin
                r_energy <= en_sum[EN_W] ? '1 : en_sum[EN_W-1:0];
            end
        end
    end

    // scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_valid <= 1'b0;
            r_idx        <= '0;
            r_hz         <= 1'b0;
            r_idle       <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_best_valid <= 1'b0;
                r_idx        <= '0;
                r_hz         <= o_status.at_horizon;
                r_idle       <= 1'b0;
            end else if (i_cmd.scan) begin
                r_idx <= r_idx + IDX_W'(1);
                if (c_ready && c_better) begin
                    r_best_valid <= 1'b1;
                end
            end else if (i_cmd.commit) begin
                r_idle <= !r_best_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_start <= r_time;
        end
        if (i_cmd.scan && c_ready && c_better) begin
            r_best_idx   <= r_idx;
            r_best_dl    <= c_dl;
            r_best_stamp <= c_stamp;
            r_best_rel   <= c_rel;
            r_best_len   <= r_len[r_idx];
            r_best_per   <= r_per[r_idx];
        end
        if (i_out_load) begin
            r_o_start  <= r_start;
            r_o_end    <= r_time;
            r_o_task   <= (r_best_valid && !r_hz) ? r_best_idx : '0;
            r_o_idle   <= r_idle && !r_hz;
            r_o_hz     <= r_hz;
            r_o_energy <= r_energy;
        end
    end

    assign o_slot_start      = r_o_start;
    assign o_slot_end        = r_o_end;
    assign o_served_task     = r_o_task;
    assign o_slot_idle       = r_o_idle;
    assign o_horizon_reached = r_o_hz;
    assign o_energy_total    = r_o_energy;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> ({1'b0, r_idx} < count_eff))
        else $error("scan index beyond task count");
    a_pick_unmarked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_best_valid) |=> !r_mark[$past(r_best_idx)])
        else $error("dispatched task still marked ready");
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("current time moved backward");
`endif

endmodule

FILE: rtl/core/edf_task_dispatcher.sv
// Top level of the EDF task dispatcher: stream ports, APB register file,
// controller and datapath. Depends on edf_pkg, edf_ctrl and edf_datapath.
//
// A load word (tuser 0) writes one task entry. A dispatch word (tuser 1)
// yields one result word. The scan visits each taking-part entry once, one
// entry per cycle; taking part are task_count entries, at most 16. A
// finished decision waits until the previous result has been taken. No
// input word is taken while a decision is in progress. No clearing pass
// follows reset.
// Registers: task_count at 0x0, horizon at 0x4.
module edf_task_dispatcher import edf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // task_index, first_arrival, run_length,
                                        // first_deadline, task_period, zero pad
    input  logic [0:0]  s_axis_tuser,   // operation
    // stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // slot_start, slot_end, served_task,
                                        // energy_total, zero pad
    output logic [1:0]  m_axis_tuser,   // slot_idle, horizon_reached
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0]  r_task_count;
    logic [HOR_W-1:0]  r_horizon;
    logic              cfg_wr;

    t_cmd              cmd;
    t_status           status;
    logic              out_load;

    logic [TIME_W-1:0] slot_start, slot_end;
    logic [IDX_W-1:0]  served_task;
    logic              slot_idle, horizon_reached;
    logic [EN_W-1:0]   energy_total;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            r_horizon    <= HOR_W'(1);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TASK_COUNT: r_task_count <= pwdata[CNT_W-1:0];
                REG_HORIZON:    r_horizon    <= pwdata[HOR_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TASK_COUNT: prdata = 32'(r_task_count);
            REG_HORIZON:    prdata = 32'(r_horizon);
            default:        prdata = '0;
        endcase
    end

    edf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_load  (out_load),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    edf_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_task_count      (r_task_count),
        .i_horizon         (r_horizon),
        .i_task_index      (s_axis_tdata[3:0]),
        .i_first_arrival   (s_axis_tdata[19:4]),
        .i_run_length      (s_axis_tdata[35:20]),
        .i_first_deadline  (s_axis_tdata[51:36]),
        .i_task_period     (s_axis_tdata[67:52]),
        .i_out_load        (out_load),
        .o_slot_start      (slot_start),
        .o_slot_end        (slot_end),
        .o_served_task     (served_task),
        .o_slot_idle       (slot_idle),
        .o_horizon_reached (horizon_reached),
        .o_energy_total    (energy_total)
    );

    assign m_axis_tdata = {2'b00, energy_total, served_task, slot_end, slot_start};
    assign m_axis_tuser = {horizon_reached, slot_idle};

endmodule

FILE: test/tb.sv
// Self-checking bench for the EDF task dispatcher: stream words in, slot words out.
// A scoreboard class keeps its own copy of the task table and checks every slot.
// Depends on edf_pkg and edf_task_dispatcher.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import edf_pkg::*;

    localparam longint unsigned TIME_MAX   = (64'd1 << TIME_W) - 1;
    localparam longint unsigned DL_MAX     = (64'd1 << DL_W) - 1;
    localparam longint unsigned ENERGY_MAX = (64'd1 << EN_W) - 1;
    localparam int unsigned     FIELD_MAX  = (1 << FIELD_W) - 1;

    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] run_len;
        logic [FIELD_W-1:0] deadline;
        logic [FIELD_W-1:0] period;
    } t_task_word;

    typedef struct packed {
        logic [TIME_W-1:0] slot_begin;
        logic [TIME_W-1:0] slot_end;
        logic [IDX_W-1:0]  served;
        logic              idle;
        logic              at_horizon;
        logic [EN_W-1:0]   energy;
    } t_slot;

    class dispatch_checker;
        logic [TIME_W-1:0]  next_rel [MAX_TASKS];
        logic [DL_W-1:0]    deadline [MAX_TASKS];
        logic [FIELD_W-1:0] run_len  [MAX_TASKS];
        logic [FIELD_W-1:0] period   [MAX_TASKS];
        logic               ready    [MAX_TASKS];
        logic [TIME_W-1:0]  stamp    [MAX_TASKS];
        logic [TIME_W-1:0]  cur_time;
        logic [EN_W-1:0]    energy;
        logic [CNT_W-1:0]   task_count;
        logic [HOR_W-1:0]   horizon;
        t_slot              pending_slots[$];
        int                 mismatches;

        function new();
            for (int i = 0; i < MAX_TASKS; i++) begin
                next_rel[i] = '0;
                deadline[i] = '0;
                run_len[i]  = '0;
                period[i]   = '0;
                ready[i]    = 1'b0;
                stamp[i]    = '0;
            end
            cur_time   = '0;
            energy     = '0;
            task_count = '0;
            horizon    = HOR_W'(1);
            mismatches = 0;
        endfunction

        function longint unsigned clip(longint unsigned v, longint unsigned cap);
            return (v > cap) ? cap : v;
        endfunction

        function void set_reg(logic sel, logic [31:0] value);
            if (sel == REG_TASK_COUNT) begin
                task_count = value[CNT_W-1:0];
            end else begin
                horizon = value[HOR_W-1:0];
            end
        endfunction

        function t_slot dispatch_decision();
            t_slot             s;
            int                active;
            int                pick;
            logic [TIME_W-1:0] t0;
            active = (task_count > MAX_TASKS) ? MAX_TASKS : int'(task_count);
            t0 = cur_time;
            s = '0;
            s.slot_begin = cur_time;
            s.slot_end   = cur_time;
            if (cur_time >= horizon) begin
                s.at_horizon = 1'b1;
                s.energy     = energy;
                return s;
            end
            for (int i = 0; i < active; i++) begin
                if (!ready[i] && next_rel[i] <= cur_time) begin
                    ready[i] = 1'b1;
                    stamp[i] = next_rel[i];
                end
            end
            // least deadline, then earliest release; strict compares keep the lower index
            pick = -1;
            for (int i = 0; i < active; i++) begin
                if (ready[i] && (pick < 0 || deadline[i] < deadline[pick] ||
                    (deadline[i] == deadline[pick] && stamp[i] < stamp[pick])))
                    pick = i;
            end
            if (pick < 0) begin
                cur_time = TIME_W'(clip(64'(cur_time) + 1, TIME_MAX));
                energy   = EN_W'(clip(64'(energy) + 64'(IDLE_ENERGY), ENERGY_MAX));
                s.idle   = 1'b1;
            end else begin
                cur_time = TIME_W'(clip(64'(cur_time) + 64'(run_len[pick]), TIME_MAX));
                energy   = EN_W'(clip(64'(energy) + 64'(BUSY_ENERGY) * 64'(cur_time - t0),
                                      ENERGY_MAX));
                next_rel[pick] = TIME_W'(clip(64'(next_rel[pick]) + 64'(period[pick]),
                                              TIME_MAX));
                deadline[pick] = DL_W'(clip(64'(deadline[pick]) + 64'(period[pick]),
                                            DL_MAX));
                ready[pick]    = 1'b0;
                s.served       = IDX_W'(pick);
            end
            s.slot_end = cur_time;
            s.energy   = energy;
            return s;
        endfunction

        function void take_word(logic op, t_task_word w);
            t_slot s;
            if (op == OP_LOAD) begin
                next_rel[w.idx] = TIME_W'(w.arrival);
                run_len[w.idx]  = w.run_len;
                deadline[w.idx] = DL_W'(w.deadline);
                period[w.idx]   = w.period;
                ready[w.idx]    = 1'b0;
                stamp[w.idx]    = '0;
            end else begin
                s = dispatch_decision();
                pending_slots.insert(pending_slots.size(), s);
            end
        endfunction

        function void check_slot(t_slot got);
            t_slot           want;
            longint unsigned exp_v [6];
            longint unsigned act_v [6];
            string           names [6];
            if (pending_slots.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected slot word, actual %h", $time, got);
                return;
            end
            want  = pending_slots.pop_front();
            names = '{"slot_start", "slot_end", "served_task", "slot_idle",
                      "horizon_reached", "energy_total"};
            exp_v = '{want.slot_begin, want.slot_end, want.served, want.idle,
                      want.at_horizon, want.energy};
            act_v = '{got.slot_begin, got.slot_end, got.served, got.idle,
                      got.at_horizon, got.energy};
            for (int k = 0; k < 6; k++) begin
                if (exp_v[k] != act_v[k]) begin
                    mismatches++;
                    $display("%0t: %s expected %0d actual %0d", $time, names[k],
                             exp_v[k], act_v[k]);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // task_index, first_arrival, run_length,
                                 // first_deadline, task_period, zero pad
    logic [0:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // slot_start, slot_end, served_task,
                                 // energy_total, zero pad
    logic [1:0]  m_axis_tuser;   // slot_idle, horizon_reached
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dispatch_checker sb = new();
    int unsigned     burst_left = 0;

    edf_task_dispatcher u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // sender: bursts of words separated by idle gaps
    task automatic send_word(logic op, t_task_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, w.period, w.deadline, w.run_len, w.arrival, w.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_word(op, w);
        burst_left--;
    endtask

    // drop valid, wait for every slot, then let the block go quiet
    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending_slots.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (30) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] count, logic [31:0] hor);
        logic        sel  [2];
        logic [31:0] vals [2];
        sel  = '{REG_TASK_COUNT, REG_HORIZON};
        vals = '{count, hor};
        for (int r = 0; r < 2; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {sel[r], 2'b00};
            pwdata  <= vals[r];
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            sb.set_reg(sel[r], vals[r]);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic t_task_word noise_word();
        return t_task_word'(68'({$urandom, $urandom, $urandom}));
    endfunction

    // mostly well-formed task: released soon after now, deadline a little later; now and then a field is random
    function automatic t_task_word make_task(logic [IDX_W-1:0] idx);
        t_task_word  w;
        int unsigned v;
        w.idx = idx;
        v = int'(sb.cur_time) + $urandom_range(0, 40);
        w.arrival = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                : 16'((v > FIELD_MAX) ? FIELD_MAX : v);
        w.run_len = 16'($urandom_range(0, 12));
        v = int'(w.arrival) + $urandom_range(0, 200);
        w.deadline = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                 : 16'((v > FIELD_MAX) ? FIELD_MAX : v);
        w.period = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
        return w;
    endfunction

    // receiver: rotate a stall pattern, swap it now and then
    initial begin
        bit [15:0]   stall_pat;
        int unsigned age;
        t_slot       got;
        stall_pat = 16'hFFFF;
        age = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.slot_begin = m_axis_tdata[16:0];
                got.slot_end   = m_axis_tdata[33:17];
                got.served     = m_axis_tdata[37:34];
                got.energy     = m_axis_tdata[61:38];
                got.idle       = m_axis_tuser[0];
                got.at_horizon = m_axis_tuser[1];
                sb.check_slot(got);
            end
            if (age == 0) begin
                age = $urandom_range(20, 80);
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
            end
            age--;
            stall_pat = {stall_pat[0], stall_pat[15:1]};
            m_axis_tready <= stall_pat[0];
        end
    end

    initial begin
        int unsigned cnt;
        int unsigned hor;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_LOAD;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: one idle tick, then the reset horizon stops everything
        send_word(OP_DISPATCH, noise_word());
        send_word(OP_DISPATCH, noise_word());

        // equal deadlines, zero run length, zero period, all-ones entry
        send_word(OP_LOAD, '{4'd0, 16'd0, 16'd3, 16'd10, 16'd20});
        send_word(OP_LOAD, '{4'd1, 16'd0, 16'd0, 16'd10, 16'd20});
        send_word(OP_LOAD, '{4'd2, 16'd2, 16'd5, 16'd10, 16'd0});
        send_word(OP_LOAD, '{4'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        for (int i = 4; i < MAX_TASKS; i++) send_word(OP_LOAD, make_task(IDX_W'(i)));
        settle();
        configure(MAX_TASKS, FIELD_MAX);
        repeat (4) send_word(OP_DISPATCH, noise_word());
        // reload an entry that may be marked ready
        send_word(OP_LOAD, '{4'd1, 16'd0, 16'd1, 16'hFFFF, 16'd1});
        repeat (2) send_word(OP_DISPATCH, noise_word());
        settle();
        configure((1 << CNT_W) - 1, FIELD_MAX);
        repeat (2) send_word(OP_DISPATCH, noise_word());

        for (int p = 0; p < 9; p++) begin
            settle();
            if (p == 0) begin
                cnt = 0;
                hor = 0;
            end else if (p == 1) begin
                cnt = MAX_TASKS;
                hor = 1;
            end else begin
                case ($urandom_range(0, 5))
                    0: begin
                        hor = $urandom_range(0, 1);
                    end
                    1: begin
                        hor = int'(sb.cur_time) + $urandom_range(0, 60);
                        if (hor > FIELD_MAX) hor = FIELD_MAX;
                    end
                    default: begin
                        hor = FIELD_MAX;
                    end
                endcase
                case ($urandom_range(0, 4))
                    0: begin
                        cnt = $urandom_range(MAX_TASKS + 1, (1 << CNT_W) - 1);
                    end
                    1: begin
                        cnt = 0;
                    end
                    default: begin
                        cnt = $urandom_range(1, MAX_TASKS);
                    end
                endcase
            end
            configure(cnt, hor);
            repeat (42) begin
                if ($urandom_range(0, 4) == 0) send_word(OP_LOAD, make_task(IDX_W'($urandom)));
                else send_word(OP_DISPATCH, noise_word());
            end
        end

        // longest job, earliest possible deadline
        settle();
        configure(MAX_TASKS, FIELD_MAX);
        send_word(OP_LOAD, '{4'd5, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
        repeat (4) send_word(OP_DISPATCH, noise_word());
        settle();

        if (sb.pending_slots.size() != 0)
            $display("%0t: %0d slot words never arrived", $time, sb.pending_slots.size());
        if (sb.mismatches == 0 && sb.pending_slots.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/edf_pkg.sv
rtl/core/edf_ctrl.sv
rtl/core/edf_datapath.sv
rtl/core/edf_task_dispatcher.sv
test/tb.sv
